// ----- sv/csvclp_pkg.sv -----
package csvclp_pkg;

  // number of fields carried on the result channel and their width
  localparam int NUM_OUT_FIELDS = 6;
  localparam int OUT_FIELD_W    = 32;
  localparam int NUM_CMDS       = 6;

  // characters with a meaning to the parser
  localparam logic [7:0] ASCII_NUL   = 8'h00;
  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;

  typedef enum logic [2:0] {
    CMD_CFGB    = 3'd0,
    CMD_AVAN    = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_RETR    = 3'd3,
    CMD_DERE    = 3'd4,
    CMD_IZQU    = 3'd5,
    CMD_UNKNOWN = 3'd6
  } cmd_code_t;

  // command names packed first char in the low byte, ordered as cmd_code_t
  localparam logic [OUT_FIELD_W-1:0] CMD_NAME [NUM_CMDS] = '{
    32'h4247_4643,  // CFGB
    32'h4E41_5641,  // AVAN
    32'h504F_5453,  // STOP
    32'h5254_4552,  // RETR
    32'h4552_4544,  // DERE
    32'h5551_5A49   // IZQU
  };

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [NUM_OUT_FIELDS-1:0][OUT_FIELD_W-1:0] fields;
    logic [2:0]                                 count;
    cmd_code_t                                  code;
    logic                                       status;
  } result_t;

endpackage

// ----- sv/csvclp_in_stage.sv -----
module csvclp_in_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  input  logic                    take,
  output csvclp_pkg::byte_item_t  item_o
);
  import csvclp_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;
  logic       accept;

  assign in_stall = vld_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (accept) begin
      vld_nxt  = 1'b1;
      data_nxt = in_rx_byte;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    data_r <= data_nxt;
  end

  assign item_o.vld  = vld_r;
  assign item_o.data = data_r;

endmodule

// ----- sv/csvclp_parse.sv -----
module csvclp_parse #(
  parameter int LINE_MAX    = 30,
  parameter int FIELD_COUNT = 6,
  parameter int FIELD_CHARS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  csvclp_pkg::byte_item_t  item_i,
  input  logic                    take,
  output logic                    needs_out,
  output logic                    res_valid,
  output csvclp_pkg::result_t     res_o
);
  import csvclp_pkg::*;

  localparam int LW  = $clog2(LINE_MAX + 1);
  localparam int FIW = $clog2(FIELD_COUNT + 1);
  localparam int CIW = $clog2(FIELD_CHARS + 1);
  localparam int FW  = 8 * FIELD_CHARS;
  localparam int EW  = (FW > OUT_FIELD_W) ? FW : OUT_FIELD_W;

  logic [LW-1:0]  len_r, len_nxt;
  logic [FIW-1:0] fidx_r, fidx_nxt;
  logic [CIW-1:0] cidx_r, cidx_nxt;
  logic [FW-1:0]  store_r [FIELD_COUNT];
  logic [FW-1:0]  store_nxt [FIELD_COUNT];
  logic           too_long_r, too_long_nxt;
  logic           ended_r, ended_nxt;

  logic full, is_nl, parsing;
  logic [NUM_OUT_FIELDS-1:0][OUT_FIELD_W-1:0] fld_w;
  logic [EW-1:0]  f0_ext;
  logic [3:0]     count_w;
  cmd_code_t      code_w;

  assign full      = len_r >= LW'(LINE_MAX);
  assign is_nl     = item_i.data == ASCII_LF;
  assign needs_out = is_nl && !full;
  assign res_valid = take && needs_out;
  assign parsing   = !ended_r && !too_long_r && (fidx_r < FIW'(FIELD_COUNT));

  always_comb begin
    len_nxt      = len_r;
    fidx_nxt     = fidx_r;
    cidx_nxt     = cidx_r;
    too_long_nxt = too_long_r;
    ended_nxt    = ended_r;
    for (int k = 0; k < FIELD_COUNT; k++) begin
      store_nxt[k] = store_r[k];
    end
    if (take) begin
      if (full || is_nl) begin
        // line closed or overrun: start a fresh line
        len_nxt      = '0;
        fidx_nxt     = '0;
        cidx_nxt     = '0;
        too_long_nxt = 1'b0;
        ended_nxt    = 1'b0;
        for (int k = 0; k < FIELD_COUNT; k++) begin
          store_nxt[k] = '0;
        end
      end else begin
        len_nxt = len_r + LW'(1);
        if (item_i.data == ASCII_NUL) begin
          ended_nxt = 1'b1;
        end else if (parsing) begin
          if (item_i.data == ASCII_COMMA) begin
            if (cidx_r != '0) begin
              fidx_nxt = fidx_r + FIW'(1);
            end
            cidx_nxt = '0;
          end else if (cidx_r >= CIW'(FIELD_CHARS)) begin
            for (int k = 0; k < FIELD_COUNT; k++) begin
              if (fidx_r == FIW'(k)) begin
                store_nxt[k] = '0;
              end
            end
            cidx_nxt     = '0;
            too_long_nxt = 1'b1;
          end else begin
            // the slot is still zero, so a plain write does the merge
            for (int k = 0; k < FIELD_COUNT; k++) begin
              for (int j = 0; j < FIELD_CHARS; j++) begin
                if (fidx_r == FIW'(k) && cidx_r == CIW'(j)) begin
                  store_nxt[k][8*j +: 8] = item_i.data;
                end
              end
            end
            cidx_nxt = cidx_r + CIW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      fidx_r     <= '0;
      cidx_r     <= '0;
      too_long_r <= 1'b0;
      ended_r    <= 1'b0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        store_r[k] <= '0;
      end
    end else begin
      len_r      <= len_nxt;
      fidx_r     <= fidx_nxt;
      cidx_r     <= cidx_nxt;
      too_long_r <= too_long_nxt;
      ended_r    <= ended_nxt;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        store_r[k] <= store_nxt[k];
      end
    end
  end

  // result fields, low 32 bits of each slot
  for (genvar g = 0; g < NUM_OUT_FIELDS; g++) begin : g_fld
    if (g < FIELD_COUNT) begin : g_used
      logic [EW-1:0] ext;
      assign ext      = EW'(store_r[g]);
      assign fld_w[g] = ext[OUT_FIELD_W-1:0];
    end else begin : g_none
      assign fld_w[g] = '0;
    end
  end

  assign f0_ext  = EW'(store_r[0]);
  assign count_w = 4'(fidx_r) +
                   4'(!too_long_r && (fidx_r < FIW'(FIELD_COUNT)) && (cidx_r != '0));

  always_comb begin
    code_w = CMD_UNKNOWN;
    // descending so the lowest matching code wins
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      if (f0_ext == EW'(CMD_NAME[k])) begin
        code_w = cmd_code_t'(k);
      end
    end
  end

  always_comb begin
    res_o.fields = fld_w;
    res_o.count  = count_w[2:0];
    res_o.code   = code_w;
    res_o.status = too_long_r;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(LINE_MAX))
    else $error("line length past limit");

  a_char_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cidx_r <= CIW'(FIELD_CHARS))
    else $error("char index past field size");

  a_overflow_stops: assert property (@(posedge clk) disable iff (!rst_n)
    too_long_r |-> cidx_r == '0)
    else $error("chars taken after field overflow");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (len_r == '0 && fidx_r == '0 && cidx_r == '0 && !too_long_r && !ended_r))
    else $error("line state not cleared after result");
`endif

endmodule

// ----- sv/csvclp_out_stage.sv -----
module csvclp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid_i,
  input  csvclp_pkg::result_t  res_i,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_free,
  output csvclp_pkg::result_t  res_o
);
  import csvclp_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r, res_nxt;

  assign out_free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r && out_stall;
    res_nxt = res_r;
    if (res_valid_i) begin
      vld_nxt = 1'b1;
      res_nxt = res_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign res_o     = res_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_i |-> !(vld_r && out_stall))
    else $error("result written over a stalled result");
`endif

endmodule

// ----- sv/csv_command_line_parser_core.sv -----
// comma separated command line parser
//
// input channel: one ascii byte per transfer on in_rx_byte (in_valid / in_stall).
// bytes build a line; a newline ends it, and if the line is not full yields one
// result transfer on the out_ channel: up to six fields of up to four chars
// (char k in bits 8k+7:8k), the field count, a command code for the first field
// and a too-long status. bytes other than a newline never produce a result.
//
// a byte is parsed as it leaves the input register, the parse stage being a
// single register step; a closing newline loads its result into the output
// register at that edge; one byte per cycle unless a newline has to wait.
//
// reset (rst_n low, synchronous) empties the input and output registers and
// clears the line state, so parsing starts on a fresh line.
// when out_stall holds a result, ordinary bytes keep flowing through the
// parser; only a closing newline waits in the input register, with
// in_stall high, until the output register frees
module csv_command_line_parser_core #(
  parameter int LINE_MAX    = 30,
  parameter int FIELD_COUNT = 6,
  parameter int FIELD_CHARS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // parsed line output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_field0,
  output logic [31:0] out_field1,
  output logic [31:0] out_field2,
  output logic [31:0] out_field3,
  output logic [31:0] out_field4,
  output logic [31:0] out_field5,
  output logic [2:0]  out_field_count,
  output logic [2:0]  out_command_code,
  output logic        out_status
);
  import csvclp_pkg::*;

  byte_item_t item;
  logic       take;       // held byte moves into the parser this edge
  logic       needs_out;  // held byte would close a line
  logic       out_free;   // output register can load this edge
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // a byte only waits when it closes a line and the result slot is busy
  assign take = item.vld && (!needs_out || out_free);

  // input register
  csvclp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .item_o     (item)
  );

  // line state and result build
  csvclp_parse #(
    .LINE_MAX    (LINE_MAX),
    .FIELD_COUNT (FIELD_COUNT),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (item),
    .take      (take),
    .needs_out (needs_out),
    .res_valid (res_valid),
    .res_o     (res)
  );

  // result register
  csvclp_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_free    (out_free),
    .res_o       (out_res)
  );

  // unpack the result onto the ports
  assign out_field0       = out_res.fields[0];
  assign out_field1       = out_res.fields[1];
  assign out_field2       = out_res.fields[2];
  assign out_field3       = out_res.fields[3];
  assign out_field4       = out_res.fields[4];
  assign out_field5       = out_res.fields[5];
  assign out_field_count  = out_res.count;
  assign out_command_code = out_res.code;
  assign out_status       = out_res.status;

endmodule

// ----- test/tb_csv_command_line_parser_core.sv -----
`timescale 1ns / 1ps

module tb_csv_command_line_parser_core;
  import csvclp_pkg::*;

  // parser sizes as built into the block
  localparam int MAX_LINE_BYTES  = 30;
  localparam int MAX_FIELDS      = 6;
  localparam int MAX_FIELD_CHARS = 4;

  // run shape
  localparam int RANDOM_BYTES   = 600;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;

  localparam logic [7:0] ASCII_CR = 8'h0D;

  // one queued byte, with flags that shape the flow around it
  typedef struct {
    logic [7:0] data;
    bit         drain_first;  // wait until every open line has come out
    bit         hold_after;   // ask the receiver for a long hold-off
  } line_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_field0;
  logic [31:0] out_field1;
  logic [31:0] out_field2;
  logic [31:0] out_field3;
  logic [31:0] out_field4;
  logic [31:0] out_field5;
  logic [2:0]  out_field_count;
  logic [2:0]  out_command_code;
  logic        out_status;

  // stimulus and scoreboard
  line_byte_t pending_bytes[$];
  result_t    expected_lines[$];
  int         queued_count = 0;
  bit         mark_drain = 1'b0;
  bit         mark_hold = 1'b0;
  int         error_count = 0;
  int         idle_cycles = 0;

  // flow control state of the driver and the receiver
  logic byte_taken = 1'b0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   stall_left = 0;
  int   recv_calm = 0;
  int   hold_left = 0;
  int   hold_asks = 0;
  int   hold_done = 0;

  // line state of the predictor
  int          line_bytes;
  int          field_at;
  int          char_at;
  logic [31:0] field_buf [MAX_FIELDS];
  logic        field_overflow;
  logic        nul_seen;

  csv_command_line_parser_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_field0       (out_field0),
    .out_field1       (out_field1),
    .out_field2       (out_field2),
    .out_field3       (out_field3),
    .out_field4       (out_field4),
    .out_field5       (out_field5),
    .out_field_count  (out_field_count),
    .out_command_code (out_command_code),
    .out_status       (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_line();
    line_bytes     = 0;
    field_at       = 0;
    char_at        = 0;
    field_overflow = 1'b0;
    nul_seen       = 1'b0;
    for (int k = 0; k < MAX_FIELDS; k++) field_buf[k] = '0;
  endfunction

  // advance the line state by one accepted byte; a closing newline queues
  // the line it ends
  task automatic parse_byte(input logic [7:0] c);
    result_t line;
    if (line_bytes >= MAX_LINE_BYTES) begin
      // line buffer full: this byte is lost and the line starts over
      clear_line();
    end else if (c != ASCII_LF) begin
      line_bytes++;
      if (c == ASCII_NUL) begin
        nul_seen = 1'b1;
      end else if (!nul_seen && !field_overflow && field_at < MAX_FIELDS) begin
        if (c == ASCII_COMMA) begin
          // empty fields do not use up a slot
          if (char_at > 0) field_at++;
          char_at = 0;
        end else if (char_at >= MAX_FIELD_CHARS) begin
          // too long: drop this field, keep the earlier ones, stop parsing
          field_buf[field_at] = '0;
          char_at = 0;
          field_overflow = 1'b1;
        end else begin
          field_buf[field_at][8*char_at +: 8] = c;
          char_at++;
        end
      end
    end else begin
      line.fields = '0;
      for (int k = 0; k < NUM_OUT_FIELDS; k++) line.fields[k] = field_buf[k];
      line.count = 3'(field_at);
      if (!field_overflow && field_at < MAX_FIELDS && char_at > 0) line.count++;
      line.code = CMD_UNKNOWN;
      for (int k = NUM_CMDS - 1; k >= 0; k--)
        if (field_buf[0] == CMD_NAME[k]) line.code = cmd_code_t'(k);
      line.status = field_overflow;
      expected_lines.push_back(line);
      clear_line();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_line();
    result_t     want;
    logic [31:0] got_fields [NUM_OUT_FIELDS];
    got_fields = '{out_field0, out_field1, out_field2, out_field3, out_field4, out_field5};
    if (expected_lines.size() == 0) begin
      report_mismatch("result with no line pending, field0", out_field0, 32'h0);
    end else begin
      want = expected_lines.pop_front();
      for (int k = 0; k < NUM_OUT_FIELDS; k++)
        if (got_fields[k] !== want.fields[k])
          report_mismatch($sformatf("field%0d", k), got_fields[k], want.fields[k]);
      if (out_field_count !== want.count)
        report_mismatch("field_count", 32'(out_field_count), 32'(want.count));
      if (out_command_code !== want.code)
        report_mismatch("command_code", 32'(out_command_code), 32'(want.code));
      if (out_status !== want.status)
        report_mismatch("status", 32'(out_status), 32'(want.status));
    end
  endtask

  // sample both channels at the rising edge; the watchdog counts edges
  // at which neither channel moves a transfer
  always @(posedge clk) begin
    if (rst_n) begin
      byte_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
      if (out_valid && !out_stall) check_line();
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
          $display("FAIL csv_command_line_parser_core");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- flow control

  // mostly back to back, some short gaps, a few long ones, and now and
  // then a calm run with no gaps at all
  function automatic int next_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = 50;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // byte driver: a held byte stays put until the edge that takes it
  always @(negedge clk) begin : drive_bytes
    line_byte_t nxt;
    if (rst_n && (!in_valid || byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0 ||
                   (pending_bytes[0].drain_first && expected_lines.size() != 0)) begin
        // nothing left, or waiting for every open line to come out
        in_valid <= 1'b0;
      end else begin
        nxt = pending_bytes.pop_front();
        if (nxt.hold_after) hold_asks++;
        in_valid   <= 1'b1;
        in_rx_byte <= nxt.data;
        send_gap = next_gap(send_calm);
      end
    end
  end

  // result receiver: random stalls, plus a long hold-off on request while
  // the sender keeps going, so the block backs up into in_stall
  always @(negedge clk) begin : drive_stall
    if (rst_n) begin
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = next_gap(recv_calm);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] c);
    line_byte_t b;
    b.data        = c;
    b.drain_first = mark_drain;
    b.hold_after  = mark_hold;
    mark_drain    = 1'b0;
    mark_hold     = 1'b0;
    pending_bytes.push_back(b);
    queued_count++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    push_byte(ASCII_LF);
  endtask

  // any byte that is neither a comma nor a newline, mostly readable
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 70) begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                      : 8'($urandom_range(8'h41, 8'h5A));
    end else begin
      c = 8'($urandom_range(1, 255));
      if (c == ASCII_COMMA || c == ASCII_LF) c = 8'h5F;
    end
    return c;
  endfunction

  // a line of random fields: command names, near misses, empty and
  // too long fields, the odd zero byte
  task automatic push_random_line();
    int nf;
    int len;
    int r;
    int pick;
    nf = $urandom_range(0, 8);
    for (int k = 0; k < nf; k++) begin
      if (k > 0 || $urandom_range(0, 9) == 0) push_byte(ASCII_COMMA);
      if ($urandom_range(0, 9) == 0) push_byte(ASCII_COMMA);
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, NUM_CMDS - 1);
      if (r < 25) begin
        for (int j = 0; j < 4; j++) push_byte(CMD_NAME[pick][8*j +: 8]);
      end else if (r < 35) begin
        // prefix of a name, or a name with one char swapped
        len = $urandom_range(0, 3);
        for (int j = 0; j < 4; j++)
          if (r < 30) begin
            if (j < 3) push_byte(CMD_NAME[pick][8*j +: 8]);
          end else begin
            push_byte(j == len ? field_char() : CMD_NAME[pick][8*j +: 8]);
          end
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        for (int j = 0; j < len; j++) push_byte(field_char());
      end
      if ($urandom_range(0, 24) == 0) push_byte(ASCII_NUL);
    end
    push_byte(ASCII_LF);
  endtask

  task automatic push_random_stimulus(input int count);
    int r;
    int n;
    int stop_at;
    stop_at = queued_count + count;
    while (queued_count < stop_at) begin
      if (queued_count > stop_at - (2 * count) / 3 && queued_count < stop_at - count / 2)
        mark_drain = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 72) begin
        push_random_line();
      end else if (r < 86) begin
        // raw noise, any byte at all
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        // line at or just past the length limit
        n = $urandom_range(29, 33);
        for (int i = 0; i < n; i++) push_byte(field_char());
        push_byte(ASCII_LF);
      end else begin
        // zero byte early, commas and text behind it
        push_text("RETR");
        push_byte(ASCII_NUL);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          push_byte($urandom_range(0, 1) ? ASCII_COMMA : field_char());
        push_byte(ASCII_LF);
      end
    end
  endtask

  initial begin
    clear_line();

    // directed lines: every command, field edge cases, line limit
    push_line("CFGB,1,22");
    push_line("AVAN");
    push_line("STOP");
    push_line("RETR");
    push_line("DERE");
    push_line("IZQU");
    push_line("");                           // empty line: unknown, no fields
    push_line(",,AB,,C,");                   // empty fields are skipped
    push_line("A,B,C,D,E,F,G,H");            // fields past the sixth ignored
    push_line("STOP,ABCDE,X");               // too long field, earlier kept
    push_text("IZQ");                        // carriage return is plain text
    push_byte(ASCII_CR);
    push_byte(ASCII_LF);
    push_text("AV");                         // zero byte ends the content
    push_byte(ASCII_NUL);
    push_line(",B,C");
    push_byte(8'hFF);                        // bytes with the top bits set
    push_byte(8'h80);
    push_byte(ASCII_COMMA);
    push_byte(8'h01);
    push_byte(8'h7F);
    push_byte(ASCII_LF);
    mark_drain = 1'b1;
    push_line("ABCD,EFGH,IJKL,MNOP,QRST,UVWX"); // longest line that still closes
    for (int i = 0; i < MAX_LINE_BYTES; i++) push_byte(8'h78);
    push_byte(8'h51);                        // full line: byte dropped, line cleared
    push_line("RETR");
    for (int i = 0; i < MAX_LINE_BYTES; i++) push_byte(8'h79);
    push_byte(ASCII_LF);                     // newline dropped at the limit, no result
    push_line("DERE,9");

    // long receiver hold-off as the random part begins and again halfway
    mark_hold = 1'b1;
    push_random_stimulus(RANDOM_BYTES / 2);
    mark_hold = 1'b1;
    push_random_stimulus(RANDOM_BYTES / 2);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every byte sent, every line out, then a short settle
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_lines.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS csv_command_line_parser_core");
    end else begin
      $display("FAIL csv_command_line_parser_core");
    end
    $finish;
  end

endmodule
